### rtl/lgpt_pkg.sv
// ----------------------------------------------------------------------------
// lgpt_pkg: shared types and constants of the gait phase timer
// item and result words, phase and command codes, register indexes
// ----------------------------------------------------------------------------
package lgpt_pkg;

    // configuration words and the serial divider
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int FRACTION_BITS = 16;
    localparam int PROG_W       = FRACTION_BITS + 1;
    // one divider run yields one quotient bit per step; integer quotients of
    // config words and fraction bits both take this many steps
    localparam int DIV_STEPS    = 16;
    localparam int QUO_W        = DIV_STEPS;

    // legs
    localparam int LEG_COUNT    = 4;
    localparam int LEG_W        = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

    localparam logic [CFG_W-1:0] CYCLE_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] SWING_RST  = 16'd500;
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd20;

    // command codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // phase codes
    localparam logic [1:0] PH_FINISHED = 2'd0;
    localparam logic [1:0] PH_BEFORE   = 2'd1;
    localparam logic [1:0] PH_SWING    = 2'd2;
    localparam logic [1:0] PH_AFTER    = 2'd3;

    // 1.0 in Q1.16
    localparam logic [PROG_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef struct packed {
        logic                    action;
        logic [LEG_W-1:0]        leg_index;
        logic signed [15:0]      from_x;
        logic signed [15:0]      from_y;
        logic signed [15:0]      from_z;
        logic signed [15:0]      to_x;
        logic signed [15:0]      to_y;
        logic signed [15:0]      to_z;
    } t_in_word;

    typedef struct packed {
        logic [LEG_W-1:0]        leg_id;
        logic [1:0]              phase;
        logic                    on_ground;
        logic [PROG_W-1:0]       swing_progress;
        logic [PROG_W-1:0]       cycle_progress;
        logic                    step_done;
        logic                    last_leg;
    } t_out_word;

endpackage

### rtl/lgpt_div.sv
// ----------------------------------------------------------------------------
// lgpt_div: bit-serial restoring divider
// one quotient bit per cycle; remainder may be preloaded for fraction runs
// ----------------------------------------------------------------------------
module lgpt_div #(
    parameter int DW = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [DW-1:0]                i_rem,
    input  logic [lgpt_pkg::CFG_W-1:0]   i_dividend,
    input  logic [DW-1:0]                i_divisor,
    output logic                         o_done,
    output logic [lgpt_pkg::QUO_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(lgpt_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lgpt_pkg::DIV_STEPS - 1);

    logic [DW-1:0]                 r_rem;
    logic [lgpt_pkg::CFG_W-1:0]    r_dvd;
    logic [DW-1:0]                 r_dvs;
    logic [lgpt_pkg::QUO_W-1:0]    r_quo;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_run;
    logic                          r_done;

    logic [DW:0]                   w_trial;
    logic                          w_fit;
    logic [DW-1:0]                 n_rem;

    // shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_dvd[lgpt_pkg::CFG_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_fit ? DW'(w_trial - {1'b0, r_dvs}) : DW'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_rem <= i_rem;
                r_dvd <= i_dividend;
                r_dvs <= i_divisor;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[lgpt_pkg::CFG_W-2:0], 1'b0};
                r_quo <= {r_quo[lgpt_pkg::QUO_W-2:0], w_fit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/leg_gait_phase_timer_core.sv
// ----------------------------------------------------------------------------
// leg_gait_phase_timer_core: per-leg gait step timer
// start items load one leg's phase counters, tick items step all legs
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the edge that takes a tick or a start
// with distinct points until its work is finished. A start item with equal
// start and target points is settled in the idle state and leaves busy low;
// any other start runs three divisions on the shared bit-serial divider (two
// when swing_duration is not below cycle_duration). A tick walks the legs in
// order: a finished leg goes from the leg state straight to emit, a running
// leg takes one divider run for cycle progress, and a leg in its swing phase
// one more for swing progress. The divider yields one quotient bit per clock.
// Each result is shown for exactly one cycle with o_result_strobe, registered
// in the emit state once the leg is settled; there is no back pressure, so
// the receiver must take every result as it comes. Configuration writes are
// taken only while the block is idle and no word is offered on start.
// ----------------------------------------------------------------------------
module leg_gait_phase_timer_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command side
    input  logic                              start,
    output logic                              busy,
    input  lgpt_pkg::t_in_word                i_item,
    // result side
    output logic                              o_result_strobe,
    output lgpt_pkg::t_out_word               o_result,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lgpt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lgpt_pkg::CFG_W-1:0]        i_cfg_data
);

    // divider must hold a count length and twice a tick period
    localparam int DIV_W = (COUNT_WIDTH > lgpt_pkg::CFG_W + 1) ?
                           COUNT_WIDTH : lgpt_pkg::CFG_W + 1;
    localparam int CW    = COUNT_WIDTH;
    localparam int PW    = lgpt_pkg::PROG_W;
    localparam int NLEG  = lgpt_pkg::LEG_COUNT;
    localparam logic [lgpt_pkg::LEG_W-1:0] LAST_LEG = lgpt_pkg::LEG_W'(NLEG - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOT,     // total = cycle / period
        ST_BEF,     // before = (cycle - swing) / (2 * period)
        ST_SWG,     // swing = swing / period, then load the leg
        ST_LEG,     // step one leg's counters
        ST_CYC,     // cycle progress fraction
        ST_SFR,     // swing progress fraction
        ST_EMIT     // put the leg's result word out
    } t_state;

    // configuration registers
    logic [lgpt_pkg::CFG_W-1:0] r_cycle_dur;
    logic [lgpt_pkg::CFG_W-1:0] r_swing_dur;
    logic [lgpt_pkg::CFG_W-1:0] r_tick_per;

    // sequencer
    t_state                       r_state;
    logic [lgpt_pkg::LEG_W-1:0]   r_leg;

    // per-leg state
    logic [CW-1:0]  r_total_left  [NLEG];
    logic [CW-1:0]  r_total_len   [NLEG];
    logic [CW-1:0]  r_before_left [NLEG];
    logic [CW-1:0]  r_swing_left  [NLEG];
    logic [CW-1:0]  r_swing_len   [NLEG];
    logic [CW-1:0]  r_after_left  [NLEG];
    logic [PW-1:0]  r_swing_frac  [NLEG];
    logic           r_foot_down   [NLEG];

    // working values of the item in flight
    logic [CW-1:0]  r_tot;
    logic [CW-1:0]  r_bef;
    logic [PW-1:0]  r_cyc;
    logic [1:0]     r_ph;
    logic           r_done;
    logic           r_cyc_one;

    // divider launch
    logic                        r_div_go;
    logic [DIV_W-1:0]            r_div_rem;
    logic [lgpt_pkg::CFG_W-1:0]  r_div_dvd;
    logic [DIV_W-1:0]            r_div_dvs;
    logic                        w_div_done;
    logic [lgpt_pkg::QUO_W-1:0]  w_div_quo;

    // result register
    lgpt_pkg::t_out_word  r_out;
    logic                 r_out_strobe;

    // saturate a divider quotient into a count
    function automatic logic [CW-1:0] sat_count(input logic [lgpt_pkg::QUO_W-1:0] q);
        logic [32:0] v_q;
        logic [32:0] v_max;
        v_q   = 33'(q);
        v_max = (33'd1 << CW) - 33'd1;
        return CW'((v_q > v_max) ? v_max : v_q);
    endfunction

    // fraction is exactly 1.0 for an empty length or a spent counter
    function automatic logic frac_one(input logic [CW-1:0] left, input logic [CW-1:0] len);
        return (len == '0) || (left == '0);
    endfunction

    // elapsed part of a length, used as the divider's starting remainder
    function automatic logic [CW-1:0] frac_rem(input logic [CW-1:0] left,
                                               input logic [CW-1:0] len);
        logic [CW-1:0] v_rem;
        v_rem = (len > left) ? len - left : '0;
        return frac_one(left, len) ? '0 : v_rem;
    endfunction

    logic [lgpt_pkg::CFG_W-1:0] w_period;
    logic [lgpt_pkg::CFG_W-1:0] w_span;
    logic                       w_same;
    logic [CW-1:0]              w_q_sat;
    logic [CW:0]                w_sb;
    logic [CW-1:0]              w_aft;
    logic [CW-1:0]              w_tl;
    logic [CW-1:0]              w_tl_dec;
    logic [CW-1:0]              w_bl;
    logic [CW-1:0]              w_sl;
    logic [CW-1:0]              w_al;
    logic [CW-1:0]              w_c_len;
    logic [CW-1:0]              w_s_left;
    logic [CW-1:0]              w_s_len;

    // zero period counts as one
    assign w_period = (r_tick_per == '0) ? lgpt_pkg::CFG_W'(1) : r_tick_per;
    assign w_span   = r_cycle_dur - r_swing_dur;
    assign w_same   = (i_item.from_x == i_item.to_x) && (i_item.from_y == i_item.to_y) &&
                      (i_item.from_z == i_item.to_z);
    assign w_q_sat  = sat_count(w_div_quo);

    // after = total - swing - before, clamped at zero
    assign w_sb  = (CW+1)'(w_q_sat) + (CW+1)'(r_bef);
    assign w_aft = ({1'b0, r_tot} > w_sb) ? CW'({1'b0, r_tot} - w_sb) : '0;

    // current leg
    assign w_tl     = r_total_left[r_leg];
    assign w_tl_dec = w_tl - 1'b1;
    assign w_bl     = r_before_left[r_leg];
    assign w_sl     = r_swing_left[r_leg];
    assign w_al     = r_after_left[r_leg];
    assign w_c_len  = r_total_len[r_leg];
    assign w_s_left = r_swing_left[r_leg];
    assign w_s_len  = r_swing_len[r_leg];

    lgpt_div #(
        .DW (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_div_go),
        .i_rem      (r_div_rem),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_dur  <= lgpt_pkg::CYCLE_RST;
            r_swing_dur  <= lgpt_pkg::SWING_RST;
            r_tick_per   <= lgpt_pkg::PERIOD_RST;
            r_state      <= ST_IDLE;
            r_leg        <= '0;
            r_div_go     <= 1'b0;
            r_out_strobe <= 1'b0;
            for (int k = 0; k < NLEG; k++) begin
                r_total_left[k]  <= '0;
                r_total_len[k]   <= '0;
                r_before_left[k] <= '0;
                r_swing_left[k]  <= '0;
                r_swing_len[k]   <= '0;
                r_after_left[k]  <= '0;
                r_swing_frac[k]  <= '0;
                r_foot_down[k]   <= 1'b1;
            end
        end else begin
            r_div_go     <= 1'b0;
            r_out_strobe <= 1'b0;

            // register writes, an unknown index is dropped
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    lgpt_pkg::CFG_CYCLE:  r_cycle_dur <= i_cfg_data;
                    lgpt_pkg::CFG_SWING:  r_swing_dur <= i_cfg_data;
                    lgpt_pkg::CFG_PERIOD: r_tick_per  <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (i_item.action == lgpt_pkg::ACT_START) begin
                            if (int'(i_item.leg_index) < NLEG) begin
                                r_leg <= i_item.leg_index;
                                if (w_same) begin
                                    // no travel: the step is empty
                                    r_total_left[i_item.leg_index]  <= '0;
                                    r_total_len[i_item.leg_index]   <= '0;
                                    r_before_left[i_item.leg_index] <= '0;
                                    r_swing_left[i_item.leg_index]  <= '0;
                                    r_swing_len[i_item.leg_index]   <= '0;
                                    r_after_left[i_item.leg_index]  <= '0;
                                    r_swing_frac[i_item.leg_index]  <= '0;
                                end else begin
                                    r_div_go  <= 1'b1;
                                    r_div_rem <= '0;
                                    r_div_dvd <= r_cycle_dur;
                                    r_div_dvs <= DIV_W'(w_period);
                                    r_state   <= ST_TOT;
                                end
                            end
                        end else begin
                            r_leg   <= '0;
                            r_state <= ST_LEG;
                        end
                    end
                end

                ST_TOT: begin
                    if (w_div_done) begin
                        r_tot     <= w_q_sat;
                        r_div_go  <= 1'b1;
                        r_div_rem <= '0;
                        if (r_cycle_dur > r_swing_dur) begin
                            r_div_dvd <= w_span;
                            r_div_dvs <= DIV_W'({w_period, 1'b0});
                            r_state   <= ST_BEF;
                        end else begin
                            r_bef     <= '0;
                            r_div_dvd <= r_swing_dur;
                            r_div_dvs <= DIV_W'(w_period);
                            r_state   <= ST_SWG;
                        end
                    end
                end

                ST_BEF: begin
                    if (w_div_done) begin
                        r_bef     <= w_q_sat;
                        r_div_go  <= 1'b1;
                        r_div_rem <= '0;
                        r_div_dvd <= r_swing_dur;
                        r_div_dvs <= DIV_W'(w_period);
                        r_state   <= ST_SWG;
                    end
                end

                ST_SWG: begin
                    if (w_div_done) begin
                        r_total_left[r_leg]  <= r_tot;
                        r_total_len[r_leg]   <= r_tot;
                        r_before_left[r_leg] <= r_bef;
                        r_swing_left[r_leg]  <= w_q_sat;
                        r_swing_len[r_leg]   <= w_q_sat;
                        r_after_left[r_leg]  <= w_aft;
                        r_swing_frac[r_leg]  <= '0;
                        r_state              <= ST_IDLE;
                    end
                end

                ST_LEG: begin
                    if (w_tl == '0) begin
                        // step over: report done, flag untouched
                        r_ph                <= lgpt_pkg::PH_FINISHED;
                        r_done              <= 1'b1;
                        r_cyc               <= lgpt_pkg::FRAC_ONE;
                        r_swing_frac[r_leg] <= lgpt_pkg::FRAC_ONE;
                        r_state             <= ST_EMIT;
                    end else begin
                        r_done              <= 1'b0;
                        r_total_left[r_leg] <= w_tl_dec;
                        r_cyc_one           <= frac_one(w_tl_dec, w_c_len);
                        r_div_go            <= 1'b1;
                        r_div_rem           <= DIV_W'(frac_rem(w_tl_dec, w_c_len));
                        r_div_dvd           <= '0;
                        r_div_dvs           <= DIV_W'(w_c_len);
                        // first unspent phase counts down
                        if (w_bl != '0) begin
                            r_before_left[r_leg] <= w_bl - 1'b1;
                            r_ph                 <= lgpt_pkg::PH_BEFORE;
                        end else if (w_sl != '0) begin
                            r_swing_left[r_leg] <= w_sl - 1'b1;
                            r_foot_down[r_leg]  <= 1'b0;
                            r_ph                <= lgpt_pkg::PH_SWING;
                        end else begin
                            r_swing_frac[r_leg] <= lgpt_pkg::FRAC_ONE;
                            r_ph                <= lgpt_pkg::PH_AFTER;
                            if (w_al != '0) begin
                                r_after_left[r_leg] <= w_al - 1'b1;
                                r_foot_down[r_leg]  <= 1'b1;
                            end
                        end
                        r_state <= ST_CYC;
                    end
                end

                ST_CYC: begin
                    if (w_div_done) begin
                        r_cyc <= r_cyc_one ? lgpt_pkg::FRAC_ONE : PW'(w_div_quo);
                        if (r_ph == lgpt_pkg::PH_SWING) begin
                            // swing counter already stepped in ST_LEG
                            r_div_go  <= 1'b1;
                            r_div_rem <= DIV_W'(frac_rem(w_s_left, w_s_len));
                            r_div_dvd <= '0;
                            r_div_dvs <= DIV_W'(w_s_len);
                            r_state   <= ST_SFR;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end

                ST_SFR: begin
                    if (w_div_done) begin
                        r_swing_frac[r_leg] <= frac_one(w_s_left, w_s_len) ?
                                               lgpt_pkg::FRAC_ONE : PW'(w_div_quo);
                        r_state             <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    r_out.leg_id         <= r_leg;
                    r_out.phase          <= r_ph;
                    r_out.on_ground      <= r_foot_down[r_leg];
                    r_out.swing_progress <= r_swing_frac[r_leg];
                    r_out.cycle_progress <= r_cyc;
                    r_out.step_done      <= r_done;
                    r_out.last_leg       <= (r_leg == LAST_LEG);
                    r_out_strobe         <= 1'b1;
                    if (r_leg == LAST_LEG) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_leg   <= r_leg + 1'b1;
                        r_state <= ST_LEG;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy            = (r_state != ST_IDLE);
    // no write at the edge that takes a word, so the word sees one set of settings
    assign o_cfg_ready     = (r_state == ST_IDLE) && !start;
    assign o_result_strobe = r_out_strobe;
    assign o_result        = r_out;

`ifndef SYNTHESIS
    // a result word only follows the emit state
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_strobe |-> $past(r_state == ST_EMIT))
        else $error("result strobe without emit");

    // divider completes only while the sequencer waits on it
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_TOT || r_state == ST_BEF || r_state == ST_SWG ||
                        r_state == ST_CYC || r_state == ST_SFR))
        else $error("divider done in a state that does not wait for it");

    // a finished leg reports phase zero and full cycle progress
    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.step_done) |->
            (o_result.phase == lgpt_pkg::PH_FINISHED &&
             o_result.cycle_progress == lgpt_pkg::FRAC_ONE))
        else $error("done word with wrong phase or progress");

    // a tick always keeps the block busy for the leg walk
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == lgpt_pkg::ACT_TICK) |=> busy)
        else $error("tick taken without going busy");
`endif

endmodule

### test/leg_gait_phase_timer_core_tb.sv
// ----------------------------------------------------------------------------
// leg_gait_phase_timer_core_tb: self-checking bench for the gait phase timer
// drives start and tick words through the command port, mirrors the per-leg
// counters in a local step predictor and checks every result word in order,
// over reset, extreme and random timing settings
// ----------------------------------------------------------------------------
module leg_gait_phase_timer_core_tb;

    // shapes of the start and target points in a start word
    localparam int PTS_APART   = 0;
    localparam int PTS_SAME    = 1;
    localparam int PTS_ONE_OFF = 2;

    // quiet time before a register write, longer than the slowest start word
    localparam int SETTLE_CYCLES = 200;
    // bound on waiting for outstanding results
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 220;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    // block ports
    logic                           start        = 1'b0;
    logic                           busy;
    lgpt_pkg::t_in_word             i_item       = '0;
    logic                           o_result_strobe;
    lgpt_pkg::t_out_word            o_result;
    logic                           i_cfg_valid  = 1'b0;
    logic                           o_cfg_ready;
    logic [lgpt_pkg::CFG_IDX_W-1:0] i_cfg_index  = lgpt_pkg::CFG_CYCLE;
    logic [lgpt_pkg::CFG_W-1:0]     i_cfg_data   = '0;

    leg_gait_phase_timer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // words waiting to be sent, result words still to come
    lgpt_pkg::t_in_word  pending_items[$];
    lgpt_pkg::t_out_word expected_words[$];

    int  mismatch_count = 0;
    int  gap_left       = 0;
    bit  idle_on        = 1'b1;

    // timing settings as the block should hold them
    logic [lgpt_pkg::CFG_W-1:0] cfg_cycle  = lgpt_pkg::CYCLE_RST;
    logic [lgpt_pkg::CFG_W-1:0] cfg_swing  = lgpt_pkg::SWING_RST;
    logic [lgpt_pkg::CFG_W-1:0] cfg_period = lgpt_pkg::PERIOD_RST;

    // per-leg step counters of the predictor
    logic [15:0]                 leg_total_left [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic [15:0]                 leg_total_len  [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic [15:0]                 leg_pre_left   [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic [15:0]                 leg_swing_left [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic [15:0]                 leg_swing_len  [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic [15:0]                 leg_post_left  [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic [lgpt_pkg::PROG_W-1:0] leg_swing_frac [lgpt_pkg::LEG_COUNT] = '{default: '0};
    logic                        leg_foot_down  [lgpt_pkg::LEG_COUNT] = '{default: 1'b1};

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // share of a phase already spent, Q1.16, a zero length counts as done
    function automatic logic [lgpt_pkg::PROG_W-1:0] q16_fraction(input int unsigned left,
                                                                 input int unsigned len);
        longint unsigned spent;
        if (len == 0)
            return lgpt_pkg::FRAC_ONE;
        spent = (len > left) ? longint'(len - left) : 64'd0;
        return lgpt_pkg::PROG_W'((spent << lgpt_pkg::FRACTION_BITS) / len);
    endfunction

    // apply one accepted word to the leg counters, queue the result words
    task automatic step_legs(input lgpt_pkg::t_in_word w);
        int unsigned per;
        int unsigned tot;
        int unsigned pre;
        int unsigned sw;
        int unsigned post;
        int          leg;
        lgpt_pkg::t_out_word r;
        if (w.action == lgpt_pkg::ACT_START) begin
            leg = int'(w.leg_index);
            tot = 0;
            pre = 0;
            sw  = 0;
            post = 0;
            // equal points leave every count at zero
            if (w.from_x != w.to_x || w.from_y != w.to_y || w.from_z != w.to_z) begin
                // a zero tick period counts as one
                per = (cfg_period == 0) ? 1 : int'(cfg_period);
                tot = cfg_cycle / per;
                pre = (cfg_cycle > cfg_swing) ? (cfg_cycle - cfg_swing) / (2 * per) : 0;
                sw  = cfg_swing / per;
                post = (tot > sw + pre) ? tot - sw - pre : 0;
            end
            leg_total_left[leg] = 16'(tot);
            leg_total_len[leg]  = 16'(tot);
            leg_pre_left[leg]   = 16'(pre);
            leg_swing_left[leg] = 16'(sw);
            leg_swing_len[leg]  = 16'(sw);
            leg_post_left[leg]  = 16'(post);
            leg_swing_frac[leg] = '0;
        end else begin
            for (int k = 0; k < lgpt_pkg::LEG_COUNT; k++) begin
                r = '0;
                r.leg_id   = lgpt_pkg::LEG_W'(k);
                r.last_leg = (k == lgpt_pkg::LEG_COUNT - 1);
                if (leg_total_left[k] == 0) begin
                    // step over, foot flag kept
                    r.phase          = lgpt_pkg::PH_FINISHED;
                    r.step_done      = 1'b1;
                    r.cycle_progress = lgpt_pkg::FRAC_ONE;
                    leg_swing_frac[k] = lgpt_pkg::FRAC_ONE;
                end else begin
                    leg_total_left[k] = leg_total_left[k] - 16'd1;
                    r.cycle_progress = q16_fraction(leg_total_left[k], leg_total_len[k]);
                    if (leg_pre_left[k] != 0) begin
                        leg_pre_left[k] = leg_pre_left[k] - 16'd1;
                        r.phase = lgpt_pkg::PH_BEFORE;
                    end else if (leg_swing_left[k] != 0) begin
                        leg_swing_left[k] = leg_swing_left[k] - 16'd1;
                        leg_swing_frac[k] = q16_fraction(leg_swing_left[k],
                                                         leg_swing_len[k]);
                        leg_foot_down[k] = 1'b0;
                        r.phase = lgpt_pkg::PH_SWING;
                    end else begin
                        // swing spent, foot lands only while the after count runs
                        leg_swing_frac[k] = lgpt_pkg::FRAC_ONE;
                        r.phase = lgpt_pkg::PH_AFTER;
                        if (leg_post_left[k] != 0) begin
                            leg_post_left[k] = leg_post_left[k] - 16'd1;
                            leg_foot_down[k] = 1'b1;
                        end
                    end
                end
                r.on_ground      = leg_foot_down[k];
                r.swing_progress = leg_swing_frac[k];
                expected_words.push_back(r);
            end
        end
    endtask

    function automatic lgpt_pkg::t_in_word tick_word();
        lgpt_pkg::t_in_word w;
        // fields other than the action are don't care on a tick
        w.action    = lgpt_pkg::ACT_TICK;
        w.leg_index = lgpt_pkg::LEG_W'($urandom);
        w.from_x    = 16'($urandom);
        w.from_y    = 16'($urandom);
        w.from_z    = 16'($urandom);
        w.to_x      = 16'($urandom);
        w.to_y      = 16'($urandom);
        w.to_z      = 16'($urandom);
        return w;
    endfunction

    function automatic lgpt_pkg::t_in_word start_word(input int leg, input int shape);
        lgpt_pkg::t_in_word w;
        w = tick_word();
        w.action    = lgpt_pkg::ACT_START;
        w.leg_index = lgpt_pkg::LEG_W'(leg);
        if (shape != PTS_APART) begin
            w.to_x = w.from_x;
            w.to_y = w.from_y;
            w.to_z = w.from_z;
        end
        // one coordinate off by a single bit
        if (shape == PTS_ONE_OFF) begin
            case ($urandom_range(0, 2))
                0: w.to_x = w.to_x ^ (16'd1 << $urandom_range(0, 15));
                1: w.to_y = w.to_y ^ (16'd1 << $urandom_range(0, 15));
                default: w.to_z = w.to_z ^ (16'd1 << $urandom_range(0, 15));
            endcase
        end
        return w;
    endfunction

    function automatic lgpt_pkg::t_in_word coord_word(input int leg,
                                                      input logic [15:0] from_v,
                                                      input logic [15:0] to_v);
        lgpt_pkg::t_in_word w;
        w = start_word(leg, PTS_APART);
        w.from_x = from_v;
        w.from_y = from_v;
        w.from_z = from_v;
        w.to_x   = to_v;
        w.to_y   = to_v;
        w.to_z   = to_v;
        return w;
    endfunction

    function automatic int pick_shape();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return PTS_SAME;
        if (r == 1)
            return PTS_ONE_OFF;
        return PTS_APART;
    endfunction

    // write one timing register, the block must be idle
    task automatic write_reg(input logic [lgpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lgpt_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lgpt_pkg::CFG_CYCLE:  cfg_cycle  = value;
            lgpt_pkg::CFG_SWING:  cfg_swing  = value;
            lgpt_pkg::CFG_PERIOD: cfg_period = value;
            default: ;
        endcase
    endtask

    // hold off until everything sent has been answered, then let a start settle
    task automatic wait_quiet();
        int c;
        c = 0;
        @(negedge i_clk);
        while (c < DRAIN_LIMIT && (pending_items.size() != 0 || start || busy
                                   || expected_words.size() != 0)) begin
            @(negedge i_clk);
            c++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // command driver: one word in flight, held until the block takes it
    always @(posedge i_clk) begin : drive_items
        if (i_rst_n) begin
            if (start && !busy) begin
                step_legs(i_item);
                if (idle_on && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 15);
            end
            // slot is free unless a word is still waiting on busy
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int got, input int want,
                               input int leg);
        if (got != want)
            report_mismatch($sformatf("leg %0d %s got %0d expected %0d",
                                      leg, name, got, want));
    endtask

    // result monitor: every strobed word is taken, no back pressure
    always @(posedge i_clk) begin : check_results
        lgpt_pkg::t_out_word want;
        if (i_rst_n && o_result_strobe) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result word for leg %0d",
                                          o_result.leg_id));
            end else begin
                want = expected_words.pop_front();
                check_field("leg_id", o_result.leg_id, want.leg_id, want.leg_id);
                check_field("phase", o_result.phase, want.phase, want.leg_id);
                check_field("on_ground", o_result.on_ground, want.on_ground, want.leg_id);
                check_field("swing_progress", o_result.swing_progress,
                            want.swing_progress, want.leg_id);
                check_field("cycle_progress", o_result.cycle_progress,
                            want.cycle_progress, want.leg_id);
                check_field("step_done", o_result.step_done, want.step_done, want.leg_id);
                check_field("last_leg", o_result.last_leg, want.last_leg, want.leg_id);
            end
        end
    end

    initial begin : stimulus
        int unsigned per;
        int unsigned cyc;
        int unsigned sw;
        int unsigned steps;
        int unsigned ticks;
        int          random_items;
        random_items = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: tick with all legs finished, extreme points,
        // equal points and points differing in one coordinate
        pending_items.push_back(tick_word());
        pending_items.push_back(coord_word(0, 16'h8000, 16'h7fff));
        pending_items.push_back(coord_word(1, 16'h7fff, 16'h8000));
        pending_items.push_back(coord_word(2, 16'hffff, 16'hffff));
        pending_items.push_back(start_word(3, PTS_ONE_OFF));
        repeat (10) pending_items.push_back(tick_word());
        wait_quiet();

        // all registers at their top: one tick of swing per step
        write_reg(lgpt_pkg::CFG_CYCLE, 16'hffff);
        write_reg(lgpt_pkg::CFG_SWING, 16'hffff);
        write_reg(lgpt_pkg::CFG_PERIOD, 16'hffff);
        pending_items.push_back(start_word(0, PTS_APART));
        pending_items.push_back(start_word(1, PTS_SAME));
        pending_items.push_back(tick_word());
        pending_items.push_back(tick_word());
        wait_quiet();

        // zero tick period counts as one, no swing, long before phase
        write_reg(lgpt_pkg::CFG_SWING, 16'd0);
        write_reg(lgpt_pkg::CFG_PERIOD, 16'd0);
        pending_items.push_back(start_word(2, PTS_APART));
        pending_items.push_back(tick_word());
        pending_items.push_back(tick_word());
        wait_quiet();

        // zero step duration with a swing longer than the step
        write_reg(lgpt_pkg::CFG_CYCLE, 16'd0);
        write_reg(lgpt_pkg::CFG_SWING, 16'hffff);
        write_reg(lgpt_pkg::CFG_PERIOD, 16'd1);
        pending_items.push_back(start_word(3, PTS_APART));
        pending_items.push_back(tick_word());
        wait_quiet();

        // random steps: a few legs started, then more ticks than steps, with the step count capped at 14
        while (random_items < RANDOM_ITEMS) begin
            if (random_items > RANDOM_ITEMS - 50)
                idle_on = 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                per = $urandom_range(1000, 65535);
                cyc = $urandom_range(0, 65535);
            end else begin
                per = $urandom_range(1, 40);
                cyc = per * $urandom_range(1, 14) + $urandom_range(0, per - 1);
            end
            if ($urandom_range(0, 3) == 0)
                sw = cyc + $urandom_range(0, 3 * per);
            else
                sw = $urandom_range(0, cyc);
            if (sw > 65535)
                sw = 65535;
            write_reg(lgpt_pkg::CFG_CYCLE, 16'(cyc));
            write_reg(lgpt_pkg::CFG_SWING, 16'(sw));
            write_reg(lgpt_pkg::CFG_PERIOD, 16'(per));

            steps = cyc / per;
            if (steps > 14)
                steps = 14;
            repeat ($urandom_range(1, 4)) begin
                pending_items.push_back(start_word($urandom_range(0, 3), pick_shape()));
                random_items++;
            end
            ticks = steps + $urandom_range(1, 3);
            for (int t = 0; t < ticks; t++) begin
                // restart a leg in mid step now and then
                if ($urandom_range(0, 9) == 0) begin
                    pending_items.push_back(start_word($urandom_range(0, 3), pick_shape()));
                    random_items++;
                end
                pending_items.push_back(tick_word());
                random_items++;
                // now and then, at mid run, the sender holds off until all results are back
                if (t == ticks / 2 && $urandom_range(0, 3) == 0)
                    wait_quiet();
            end
            wait_quiet();
        end

        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_words.size()));
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
